// ----- design/v2a_pkg.sv -----
// Shared constants, opcodes and stage payload types for the 2D vector unit.
package v2a_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned EXT_W      = WORD_BITS + 1;
  localparam int unsigned PROD_W     = 2 * EXT_W;
  localparam int unsigned ACC_W      = PROD_W + 1;
  localparam int unsigned ROOT_W     = WORD_BITS;
  localparam int unsigned RAD_W      = 2 * WORD_BITS;
  localparam int unsigned QUOT_W     = FRAC_BITS + 1;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned LANE_DEPTH = 2;
  localparam int unsigned PIPE_DEPTH = LANE_DEPTH + 1 + ROOT_W + QUOT_W;

  localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  // Normalize divides only by lengths above this bound; (1 << FRAC_BITS) / 100000 truncates to 0
  localparam logic [ROOT_W-1:0] NORM_MIN_RAW = ROOT_W'((1 << FRAC_BITS) / 100000);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DOT   = 4'd4,
    OP_SQLEN = 4'd5,
    OP_LEN   = 4'd6,
    OP_DIST  = 4'd7,
    OP_NORM  = 4'd8,
    OP_EQUAL = 4'd9
  } op_e;

  // Per-component lane result after the multiplier stage
  typedef struct packed {
    logic [EXT_W-1:0]  res;
    logic              big;
    logic [PROD_W-1:0] prod;
  } lane_t;

  // Partial result carried along the root and divide pipelines
  typedef struct packed {
    op_e                  op;
    logic [WORD_BITS-1:0] rx;
    logic [WORD_BITS-1:0] ry;
    logic [WORD_BITS-1:0] sv;
    logic                 eq;
    logic                 sat;
    logic                 take_root;
    logic [WORD_BITS-1:0] ax;
    logic [WORD_BITS-1:0] ay;
  } side_t;

endpackage

// ----- design/v2a_lane.sv -----
// One component lane: add/subtract, operand select and a registered multiplier.
module v2a_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  v2a_pkg::op_e                        op_i,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] a_i,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] b_i,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] s_i,
  output v2a_pkg::lane_t                      lane_o
);

  localparam int unsigned W = v2a_pkg::WORD_BITS;
  localparam int unsigned E = v2a_pkg::EXT_W;

  logic signed [E-1:0] a_ext, b_ext, s_ext, sum, diff;
  logic        [E-1:0] dmag;
  logic signed [E-1:0] m1_d, m2_d, m1_q, m2_q;
  logic        [E-1:0] res_d, res_q;
  logic                big_d, big_q;
  logic signed [v2a_pkg::PROD_W-1:0] prod_d;
  v2a_pkg::lane_t      lane_q;

  // Sum, difference and multiplier operands
  always_comb begin
    a_ext = {a_i[W-1], a_i};
    b_ext = {b_i[W-1], b_i};
    s_ext = {s_i[W-1], s_i};
    sum   = a_ext + b_ext;
    diff  = a_ext - b_ext;
    dmag  = diff[E-1] ? E'(-diff) : diff;
    big_d = dmag > E'(v2a_pkg::SMAX);
    res_d = (op_i == v2a_pkg::OP_SUB) ? diff : sum;
    m1_d  = a_ext;
    m2_d  = b_ext;
    unique case (op_i) inside
      v2a_pkg::OP_SCALE: begin
        m2_d = s_ext;
      end
      v2a_pkg::OP_SQLEN, v2a_pkg::OP_LEN, v2a_pkg::OP_NORM: begin
        m2_d = a_ext;
      end
      v2a_pkg::OP_DIST, v2a_pkg::OP_EQUAL: begin
        m1_d = diff;
        m2_d = diff;
      end
      default: begin
        m2_d = b_ext;
      end
    endcase
  end

  // Operand stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      res_q <= res_d;
      big_q <= big_d;
    end
  end

  assign prod_d = m1_q * m2_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q.prod <= prod_d;
      lane_q.res  <= res_q;
      lane_q.big  <= big_q;
    end
  end

  assign lane_o = lane_q;

endmodule

// ----- design/v2a_merge.sv -----
// Merge stage: combines both lanes into sums, saturated results and the radicand.
module v2a_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  v2a_pkg::op_e                      op_i,
  input  logic [v2a_pkg::WORD_BITS-1:0]     ax_i,
  input  logic [v2a_pkg::WORD_BITS-1:0]     ay_i,
  input  v2a_pkg::lane_t                    lx_i,
  input  v2a_pkg::lane_t                    ly_i,
  input  logic [v2a_pkg::THR_W-1:0]         thr_i,
  output v2a_pkg::side_t                    side_o,
  output logic [v2a_pkg::RAD_W-1:0]         rad_o
);

  localparam int unsigned W  = v2a_pkg::WORD_BITS;
  localparam int unsigned AW = v2a_pkg::ACC_W;
  localparam int unsigned F  = v2a_pkg::FRAC_BITS;

  // Clamp to the signed word range; top bit of the result is the clamp flag
  function automatic logic [W:0] sat_fn(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(signed'({1'b0, v2a_pkg::SMAX}));
    lo = -hi - AW'(1);
    if (v > hi) begin
      sat_fn = {1'b1, v2a_pkg::SMAX};
    end else if (v < lo) begin
      sat_fn = {1'b1, v2a_pkg::SMIN};
    end else begin
      sat_fn = {1'b0, v[W-1:0]};
    end
  endfunction

  logic signed [AW-1:0] px, py, acc, acc_sh, px_sh, py_sh, rxe, rye;
  logic [W:0] sx, sy, ss;
  v2a_pkg::side_t side_d, side_q;
  logic [v2a_pkg::RAD_W-1:0] rad_q;

  always_comb begin
    px     = AW'($signed(lx_i.prod));
    py     = AW'($signed(ly_i.prod));
    rxe    = AW'($signed(lx_i.res));
    rye    = AW'($signed(ly_i.res));
    acc    = px + py;
    acc_sh = acc >>> F;
    px_sh  = px >>> F;
    py_sh  = py >>> F;
    sx     = sat_fn(rxe);
    sy     = sat_fn(rye);
    ss     = sat_fn(acc_sh);
    side_d           = '0;
    side_d.op        = op_i;
    side_d.ax        = ax_i;
    side_d.ay        = ay_i;
    unique case (op_i) inside
      v2a_pkg::OP_ADD, v2a_pkg::OP_SUB: begin
        side_d.rx  = sx[W-1:0];
        side_d.ry  = sy[W-1:0];
        side_d.sat = sx[W] | sy[W];
      end
      v2a_pkg::OP_MUL, v2a_pkg::OP_SCALE: begin
        sx         = sat_fn(px_sh);
        sy         = sat_fn(py_sh);
        side_d.rx  = sx[W-1:0];
        side_d.ry  = sy[W-1:0];
        side_d.sat = sx[W] | sy[W];
      end
      v2a_pkg::OP_DOT, v2a_pkg::OP_SQLEN: begin
        side_d.sv  = ss[W-1:0];
        side_d.sat = ss[W];
      end
      v2a_pkg::OP_LEN: begin
        side_d.take_root = 1'b1;
      end
      v2a_pkg::OP_DIST: begin
        // Out-of-range component difference pins the distance at the maximum
        if (lx_i.big || ly_i.big) begin
          side_d.sv  = v2a_pkg::SMAX;
          side_d.sat = 1'b1;
        end else begin
          side_d.take_root = 1'b1;
        end
      end
      v2a_pkg::OP_NORM: begin
        side_d.take_root = 1'b1;
        side_d.rx        = ax_i;
        side_d.ry        = ay_i;
      end
      v2a_pkg::OP_EQUAL: begin
        side_d.eq = !lx_i.big && !ly_i.big &&
                    ($unsigned(acc_sh) < AW'(thr_i));
      end
      default: begin
        side_d.op = op_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      rad_q  <= acc[v2a_pkg::RAD_W-1:0];
    end
  end

  assign side_o = side_q;
  assign rad_o  = rad_q;

endmodule

// ----- design/v2a_isqrt.sv -----
// Pipelined floor square root, one root bit per stage, with the partial result riding along.
module v2a_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [v2a_pkg::RAD_W-1:0]     rad_i,
  input  v2a_pkg::side_t                side_i,
  output logic [v2a_pkg::ROOT_W-1:0]    root_o,
  output v2a_pkg::side_t                side_o
);

  localparam int unsigned RB   = v2a_pkg::ROOT_W;
  localparam int unsigned RW   = v2a_pkg::RAD_W;
  localparam int unsigned REMW = RB + 2;

  logic [REMW-1:0]  rem_q  [RB];
  logic [RB-1:0]    root_q [RB];
  logic [RW-1:0]    rad_q  [RB];
  v2a_pkg::side_t   side_q [RB];

  for (genvar g = 0; g < RB; g++) begin : g_stage
    logic [REMW-1:0]  rem_in;
    logic [RB-1:0]    root_in;
    logic [RW-1:0]    rad_in;
    v2a_pkg::side_t   side_in;
    logic [REMW+1:0]  rem_sh, trial, rem_sub;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh  = {rem_in, rad_in[RW-1 -: 2]};
      trial   = {2'b00, root_in, 2'b01};
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? rem_sub[REMW-1:0] : rem_sh[REMW-1:0];
        root_q[g] <= {root_in[RB-2:0], ge};
        rad_q[g]  <= rad_in << 2;
        side_q[g] <= side_in;
      end
    end
  end

  assign root_o = root_q[RB-1];
  assign side_o = side_q[RB-1];

endmodule

// ----- design/v2a_ndiv.sv -----
// Pipelined restoring divider for one normalize lane: |c| * 2^FRAC / d, one quotient bit per stage.
module v2a_ndiv (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [v2a_pkg::WORD_BITS-1:0]      c_i,
  input  logic [v2a_pkg::ROOT_W-1:0]         d_i,
  output logic [v2a_pkg::QUOT_W-1:0]         q_o,
  output logic                               neg_o
);

  localparam int unsigned W  = v2a_pkg::WORD_BITS;
  localparam int unsigned QB = v2a_pkg::QUOT_W;
  localparam int unsigned DW = v2a_pkg::ROOT_W;
  localparam int unsigned NW = W + v2a_pkg::FRAC_BITS;

  logic [W-1:0]  mag;
  logic [NW-1:0] num;
  logic [DW-1:0] rem0;

  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] bits_q [QB];
  logic [QB-1:0] quo_q  [QB];
  logic [DW-1:0] div_q  [QB];
  logic          neg_q  [QB];

  // Magnitude scaled by the fraction; the top part starts as the remainder
  always_comb begin
    mag  = c_i[W-1] ? W'(-c_i) : c_i;
    num  = {mag, {v2a_pkg::FRAC_BITS{1'b0}}};
    rem0 = DW'(num[NW-1:QB]);
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DW-1:0] rem_in, div_in;
    logic [QB-1:0] bits_in, quo_in;
    logic          neg_in;
    logic [DW:0]   rem_sh, rem_sub;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in  = rem0;
      assign bits_in = num[QB-1:0];
      assign quo_in  = '0;
      assign div_in  = d_i;
      assign neg_in  = c_i[W-1];
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign bits_in = bits_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign div_in  = div_q[g-1];
      assign neg_in  = neg_q[g-1];
    end

    // Shift in one dividend bit and subtract the divisor when it fits
    always_comb begin
      rem_sh  = {rem_in, bits_in[QB-1]};
      ge      = rem_sh >= {1'b0, div_in};
      rem_sub = rem_sh - {1'b0, div_in};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        bits_q[g] <= bits_in << 1;
        quo_q[g]  <= {quo_in[QB-2:0], ge};
        div_q[g]  <= div_in;
        neg_q[g]  <= neg_in;
      end
    end
  end

  assign q_o   = quo_q[QB-1];
  assign neg_o = neg_q[QB-1];

endmodule

// ----- design/vec2_arith_unit.sv -----
// Top level of the 2D vector unit: stream ports, threshold register, lanes and output buffer.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the opcode, tdata the
//   vectors a = (ax, ay) and b = (bx, by) in signed Q16.16. Each request gives
//   exactly one result on the m_axis channel, in request order: vector result,
//   scalar result, equality flag and saturation flag.
//   The equality threshold is written over the APB port at byte address 0;
//   write it only while no request is in flight.
//   Every opcode takes the same path: the accepting edge loads the operand
//   register, then one multiply stage, one merge stage, 32 square-root stages
//   (one root bit each), 17 divider stages (one quotient bit each for
//   normalize) and the output register, all passed by every request.
//   Throughput is one request per cycle while results are taken.
//   An output register plus a skid register sit behind the pipeline. When the
//   receiver stalls, one more result lands in the skid register, then
//   s_axis_tready drops and the whole pipeline holds until the output drains.
//   Reset clears all valid bits and sets the threshold to 1.
module vec2_arith_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // ax[31:0], ay[63:32], bx[95:64], by[127:96]
  input  logic [3:0]   s_axis_tuser,   // opcode[3:0]
  // Result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // rx[31:0], ry[63:32], scalar_value[95:64],
                                       // is_equal[96], saturated[97], zero[103:98]
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned W     = v2a_pkg::WORD_BITS;
  localparam int unsigned QB    = v2a_pkg::QUOT_W;
  localparam int unsigned DEPTH = v2a_pkg::PIPE_DEPTH;
  localparam logic REG_EQ_THR   = 1'b0;
  localparam int unsigned OUT_W = 104;

  logic en;
  logic [DEPTH-1:0] vld_q;

  // Threshold register
  logic [v2a_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= v2a_pkg::THR_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_EQ_THR)) begin
      thr_q <= pwdata[v2a_pkg::THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EQ_THR) ? {1'b0, thr_q} : '0;

  // Unpack request
  v2a_pkg::op_e      op_in;
  logic signed [W-1:0] ax_in, ay_in, bx_in, by_in;

  assign op_in = v2a_pkg::op_e'(s_axis_tuser);
  assign ax_in = s_axis_tdata[W-1:0];
  assign ay_in = s_axis_tdata[2*W-1:W];
  assign bx_in = s_axis_tdata[3*W-1:2*W];
  assign by_in = s_axis_tdata[4*W-1:3*W];

  // Component lanes
  v2a_pkg::lane_t lane_x, lane_y;

  v2a_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .op_i   (op_in),
    .a_i    (ax_in),
    .b_i    (bx_in),
    .s_i    (bx_in),
    .lane_o (lane_x)
  );

  v2a_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .op_i   (op_in),
    .a_i    (ay_in),
    .b_i    (by_in),
    .s_i    (bx_in),
    .lane_o (lane_y)
  );

  // Match the lane latency for opcode and vector a
  v2a_pkg::op_e  op_dl_q [v2a_pkg::LANE_DEPTH];
  logic [W-1:0]  ax_dl_q [v2a_pkg::LANE_DEPTH];
  logic [W-1:0]  ay_dl_q [v2a_pkg::LANE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_dl_q[0] <= op_in;
      ax_dl_q[0] <= ax_in;
      ay_dl_q[0] <= ay_in;
      for (int i = 1; i < v2a_pkg::LANE_DEPTH; i++) begin
        op_dl_q[i] <= op_dl_q[i-1];
        ax_dl_q[i] <= ax_dl_q[i-1];
        ay_dl_q[i] <= ay_dl_q[i-1];
      end
    end
  end

  // Merge lanes
  v2a_pkg::side_t side_m;
  logic [v2a_pkg::RAD_W-1:0] rad_m;

  v2a_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .op_i   (op_dl_q[v2a_pkg::LANE_DEPTH-1]),
    .ax_i   (ax_dl_q[v2a_pkg::LANE_DEPTH-1]),
    .ay_i   (ay_dl_q[v2a_pkg::LANE_DEPTH-1]),
    .lx_i   (lane_x),
    .ly_i   (lane_y),
    .thr_i  (thr_q),
    .side_o (side_m),
    .rad_o  (rad_m)
  );

  // Square root
  v2a_pkg::side_t side_r;
  logic [v2a_pkg::ROOT_W-1:0] root_r;

  v2a_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_m),
    .side_i (side_m),
    .root_o (root_r),
    .side_o (side_r)
  );

  // Normalize dividers, one per component
  logic [QB-1:0] qx, qy;
  logic          negx, negy;

  v2a_ndiv u_ndiv_x (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (side_r.ax),
    .d_i   (root_r),
    .q_o   (qx),
    .neg_o (negx)
  );

  v2a_ndiv u_ndiv_y (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (side_r.ay),
    .d_i   (root_r),
    .q_o   (qy),
    .neg_o (negy)
  );

  // Carry partial result and root past the dividers
  v2a_pkg::side_t              side_dl_q [QB];
  logic [v2a_pkg::ROOT_W-1:0]  root_dl_q [QB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl_q[0] <= side_r;
      root_dl_q[0] <= root_r;
      for (int i = 1; i < QB; i++) begin
        side_dl_q[i] <= side_dl_q[i-1];
        root_dl_q[i] <= root_dl_q[i-1];
      end
    end
  end

  // Final assembly
  v2a_pkg::side_t             fin;
  logic [v2a_pkg::ROOT_W-1:0] root_f;
  logic [W-1:0]               qx_ext, qy_ext;
  logic [OUT_W-1:0]           push_data;

  always_comb begin
    fin    = side_dl_q[QB-1];
    root_f = root_dl_q[QB-1];
    qx_ext = W'(qx);
    qy_ext = W'(qy);
    if (fin.take_root) begin
      fin.sv  = root_f[W-1] ? v2a_pkg::SMAX : root_f;
      fin.sat = fin.sat | root_f[W-1];
    end
    if ((fin.op == v2a_pkg::OP_NORM) && (root_f > v2a_pkg::NORM_MIN_RAW)) begin
      fin.rx = negx ? W'(-qx_ext) : qx_ext;
      fin.ry = negy ? W'(-qy_ext) : qy_ext;
    end
    push_data = {6'b0, fin.sat, fin.eq, fin.sv, fin.ry, fin.rx};
  end

  // Valid line through the whole pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Output register with skid stage
  logic             out_vld_q, skid_vld_q;
  logic [OUT_W-1:0] out_q, skid_q;
  logic             push, pop;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign push          = en && vld_q[DEPTH-1];
  assign pop           = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_q <= push;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || pop) begin
      out_q <= push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
